@@ hdl/trbd_pkg.sv @@
// Shared types and constants of the track block run-length decoder.
package trbd_pkg;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_SIZE_HI = 3'd1,
		PH_RUN_LO  = 3'd2,
		PH_RUN_HI  = 3'd3,
		PH_LITERAL = 3'd4,
		PH_REPEAT  = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_PACKED   = 3'd1,
		ST_TRUNC    = 3'd2,
		ST_LITOVER  = 3'd3,
		ST_REPMISS  = 3'd4,
		ST_OVERFLOW = 3'd5,
		ST_MISMATCH = 3'd6
	} status_t;

	localparam logic [15:0] MAX_TRACK_BYTES = 16'h8000;
	localparam logic [15:0] TRACK_SIZE_RST  = 16'd512;

	// queued request, with the byte's top bit split out for the word-type test
	typedef struct packed {
		logic [7:0] data_byte;
		logic       block_start;
		logic       hi_set;
	} item_t;

	typedef struct packed {
		logic [7:0]  run_byte;
		logic [15:0] run_length;
		status_t     status;
		logic        last;
	} result_t;

endpackage

@@ hdl/trbd_front.sv @@
// Front end: accepts input requests, classifies them and queues them (two entries).
module trbd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  logic [7:0]        data_byte,
	input  logic              block_start,
	output logic              head_valid,
	output trbd_pkg::item_t   head,
	input  logic              pop
);

	logic [1:0]      count_q;
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	trbd_pkg::item_t entry_q [2];
	trbd_pkg::item_t new_item;
	logic            push;

	assign item_ready = (count_q != 2'd2);
	assign push       = item_valid & item_ready;
	assign head_valid = (count_q != 2'd0);
	assign head       = entry_q[rd_ptr_q];

	always_comb begin
		new_item.data_byte   = data_byte;
		new_item.block_start = block_start;
		new_item.hi_set      = data_byte[7];
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
		end
	end

endmodule

@@ hdl/trbd_back.sv @@
// Back end: run-length decode state machine and the output register.
module trbd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  trbd_pkg::item_t   head,
	output logic              pop,
	input  logic [15:0]       limit,
	output logic              run_valid,
	input  logic              run_ready,
	output trbd_pkg::result_t result
);

	trbd_pkg::phase_t  phase_q, phase_d;
	logic [15:0]       rem_q, rem_d;
	logic [15:0]       prod_q, prod_d;
	logic [15:0]       ll_q, ll_d;
	logic [7:0]        hold_q, hold_d;
	logic              out_valid_q;
	trbd_pkg::result_t out_q;

	trbd_pkg::result_t res;
	logic              res_valid;

	logic [15:0] word;
	logic [16:0] cnt_rep;
	logic [15:0] size_rem;
	logic [15:0] rem_m1, rem_m2, ll_m1;
	logic [17:0] prod_sum;
	logic        trunc_err, litover, over, repmiss;
	logic [15:0] done_rem, done_prod;
	logic        done_end, done_one;
	trbd_pkg::phase_t done_ph;

	function automatic trbd_pkg::result_t finish(input logic [7:0] b, input logic [15:0] len,
			input logic at_end, input logic at_one, input logic match);
		trbd_pkg::result_t r;
		r.run_byte   = b;
		r.run_length = len;
		r.last       = at_end | at_one;
		if (at_end) begin
			r.status = match ? trbd_pkg::ST_OK : trbd_pkg::ST_MISMATCH;
		end else if (at_one) begin
			r.status = trbd_pkg::ST_TRUNC;
		end else begin
			r.status = trbd_pkg::ST_OK;
		end
		return r;
	endfunction

	function automatic trbd_pkg::result_t fail(input trbd_pkg::status_t st);
		trbd_pkg::result_t r;
		r.run_byte   = 8'd0;
		r.run_length = 16'd0;
		r.status     = st;
		r.last       = 1'b1;
		return r;
	endfunction

	assign pop = head_valid & (~out_valid_q | run_ready);

	assign word     = {head.data_byte, hold_q};
	assign cnt_rep  = 17'h10000 - {1'b0, word};
	assign size_rem = cnt_rep[15:0];
	assign rem_m1   = rem_q - 16'd1;
	assign rem_m2   = rem_q - 16'd2;
	assign ll_m1    = ll_q - 16'd1;
	// one adder serves both run kinds: literal count or repeat count
	assign prod_sum = {2'b00, prod_q} + (head.hi_set ? {1'b0, cnt_rep} : {2'b00, word});
	assign over      = prod_sum > {2'b00, limit};
	assign trunc_err = rem_q < 16'd2;
	assign litover   = rem_m2 < word;
	assign repmiss   = (rem_m2 == 16'd0);

	// counters as they stand once the current run is finished
	always_comb begin
		case (phase_q)
			trbd_pkg::PH_SIZE_HI: begin
				done_rem  = size_rem;
				done_prod = 16'd0;
			end
			trbd_pkg::PH_RUN_HI: begin
				done_rem  = rem_m2;
				done_prod = prod_q;
			end
			trbd_pkg::PH_LITERAL: begin
				done_rem  = rem_m1;
				done_prod = prod_q + 16'd1;
			end
			default: begin
				done_rem  = rem_m1;
				done_prod = prod_q + ll_q;
			end
		endcase
	end

	assign done_end = (done_rem == 16'd0);
	assign done_one = (done_rem == 16'd1);
	assign done_ph  = (done_end | done_one) ? trbd_pkg::PH_IDLE : trbd_pkg::PH_RUN_LO;

	always_comb begin
		phase_d = phase_q;
		if (head.block_start) begin
			phase_d = trbd_pkg::PH_SIZE_HI;
		end else begin
			unique case (phase_q)
				trbd_pkg::PH_IDLE: begin
					phase_d = trbd_pkg::PH_IDLE;
				end
				trbd_pkg::PH_SIZE_HI: begin
					phase_d = head.hi_set ? done_ph : trbd_pkg::PH_IDLE;
				end
				trbd_pkg::PH_RUN_LO: begin
					phase_d = trbd_pkg::PH_RUN_HI;
				end
				trbd_pkg::PH_RUN_HI: begin
					if (trunc_err) begin
						phase_d = trbd_pkg::PH_IDLE;
					end else if (!head.hi_set) begin
						if (litover || over) begin
							phase_d = trbd_pkg::PH_IDLE;
						end else if (word == 16'd0) begin
							phase_d = done_ph;
						end else begin
							phase_d = trbd_pkg::PH_LITERAL;
						end
					end else begin
						phase_d = (repmiss || over) ? trbd_pkg::PH_IDLE : trbd_pkg::PH_REPEAT;
					end
				end
				trbd_pkg::PH_LITERAL: begin
					phase_d = (ll_m1 != 16'd0) ? trbd_pkg::PH_LITERAL : done_ph;
				end
				trbd_pkg::PH_REPEAT: begin
					phase_d = done_ph;
				end
				default: begin
					phase_d = trbd_pkg::PH_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		rem_d     = rem_q;
		prod_d    = prod_q;
		ll_d      = ll_q;
		hold_d    = hold_q;
		res_valid = 1'b0;
		res       = fail(trbd_pkg::ST_OK);
		if (head.block_start) begin
			hold_d    = head.data_byte;
			rem_d     = 16'd0;
			prod_d    = 16'd0;
			ll_d      = 16'd0;
			res_valid = (phase_q != trbd_pkg::PH_IDLE);
			case (phase_q)
				trbd_pkg::PH_LITERAL: res = fail(trbd_pkg::ST_LITOVER);
				trbd_pkg::PH_REPEAT:  res = fail(trbd_pkg::ST_REPMISS);
				default:              res = fail(trbd_pkg::ST_TRUNC);
			endcase
		end else begin
			unique case (phase_q)
				trbd_pkg::PH_SIZE_HI: begin
					if (head.hi_set) begin
						rem_d     = size_rem;
						prod_d    = 16'd0;
						res       = finish(8'd0, 16'd0, done_end, done_one,
							done_prod == limit);
						res_valid = done_end | done_one;
					end else begin
						res       = fail(trbd_pkg::ST_PACKED);
						res_valid = 1'b1;
					end
				end
				trbd_pkg::PH_RUN_LO: begin
					hold_d = head.data_byte;
				end
				trbd_pkg::PH_RUN_HI: begin
					if (trunc_err) begin
						res       = fail(trbd_pkg::ST_TRUNC);
						res_valid = 1'b1;
					end else begin
						rem_d = rem_m2;
						if (!head.hi_set) begin
							if (litover) begin
								res       = fail(trbd_pkg::ST_LITOVER);
								res_valid = 1'b1;
							end else if (over) begin
								res       = fail(trbd_pkg::ST_OVERFLOW);
								res_valid = 1'b1;
							end else begin
								ll_d = word;
								if (word == 16'd0) begin
									res       = finish(8'd0, 16'd0, done_end, done_one,
										done_prod == limit);
									res_valid = done_end | done_one;
								end
							end
						end else begin
							if (repmiss) begin
								res       = fail(trbd_pkg::ST_REPMISS);
								res_valid = 1'b1;
							end else if (over) begin
								res       = fail(trbd_pkg::ST_OVERFLOW);
								res_valid = 1'b1;
							end else begin
								ll_d = cnt_rep[15:0];
							end
						end
					end
				end
				trbd_pkg::PH_LITERAL: begin
					prod_d    = done_prod;
					rem_d     = rem_m1;
					ll_d      = ll_m1;
					res_valid = 1'b1;
					if (ll_m1 != 16'd0) begin
						res = finish(head.data_byte, 16'd1, 1'b0, 1'b0, 1'b0);
					end else begin
						res = finish(head.data_byte, 16'd1, done_end, done_one,
							done_prod == limit);
					end
				end
				trbd_pkg::PH_REPEAT: begin
					prod_d    = done_prod;
					rem_d     = rem_m1;
					ll_d      = 16'd0;
					res_valid = 1'b1;
					res       = finish(head.data_byte, ll_q, done_end, done_one,
						done_prod == limit);
				end
				default: begin
					res_valid = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= trbd_pkg::PH_IDLE;
			rem_q       <= 16'd0;
			prod_q      <= 16'd0;
			ll_q        <= 16'd0;
			hold_q      <= 8'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q     <= phase_d;
				rem_q       <= rem_d;
				prod_q      <= prod_d;
				ll_q        <= ll_d;
				hold_q      <= hold_d;
				out_valid_q <= res_valid;
			end else if (run_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && res_valid) begin
			out_q <= res;
		end
	end

	assign run_valid = out_valid_q;
	assign result    = out_q;

endmodule

@@ hdl/track_rle_block_decoder_core.sv @@
// Track block run-length decoder: top level with the track size register.
//
// Input channel (item_valid/item_ready): one coded byte per request, with
// block_start marking the low byte of a block's size word. Output channel
// (run_valid/run_ready): one decoded run per result, run_byte repeated
// run_length times, with status and last closing each block.
// cfg_wr_en/cfg_wr_data load track_size at any edge; write it only while idle.
//
// Throughput: one byte per cycle unless the receiver stalls. The front end
// queues requests in a two-entry buffer; the back end consumes one byte per
// cycle in its state machine, which holds only small counters and one
// add/compare per byte. An accepted byte is registered in the queue; the back
// end decodes it from the queue head and loads any result into out_q.
// When the receiver stalls, the output register holds its result and the
// back end stops; item_ready drops once both queue entries hold requests.
// Reset empties the queue and output, returns to waiting for a
// block start and sets track_size to 512.
module track_rle_block_decoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [7:0]  data_byte,
	input  logic        block_start,
	output logic        run_valid,
	input  logic        run_ready,
	output logic [7:0]  run_byte,
	output logic [15:0] run_length,
	output logic [2:0]  status,
	output logic        last,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data
);

	logic [15:0]       track_size_q;
	logic [15:0]       limit;
	logic              head_valid;
	trbd_pkg::item_t   head;
	logic              pop;
	trbd_pkg::result_t result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			track_size_q <= trbd_pkg::TRACK_SIZE_RST;
		end else if (cfg_wr_en) begin
			track_size_q <= cfg_wr_data;
		end
	end

	assign limit = (track_size_q > trbd_pkg::MAX_TRACK_BYTES) ?
		trbd_pkg::MAX_TRACK_BYTES : track_size_q;

	trbd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.data_byte   (data_byte),
		.block_start (block_start),
		.head_valid  (head_valid),
		.head        (head),
		.pop         (pop)
	);

	trbd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.limit      (limit),
		.run_valid  (run_valid),
		.run_ready  (run_ready),
		.result     (result)
	);

	assign run_byte   = result.run_byte;
	assign run_length = result.run_length;
	assign status     = result.status;
	assign last       = result.last;

	// an empty run carries no byte
	a_empty_run_zero: assert property (@(posedge clk) disable iff (!arst_n)
		run_valid && run_length == 16'd0 |-> run_byte == 8'd0)
		else $error("empty run with nonzero byte");

	// hard errors end the block and carry no run
	a_error_closes: assert property (@(posedge clk) disable iff (!arst_n)
		run_valid && status != trbd_pkg::ST_OK && status != trbd_pkg::ST_TRUNC &&
		status != trbd_pkg::ST_MISMATCH |-> last && run_length == 16'd0)
		else $error("error result not closing the block");

	// a result inside a block is always a real run with ok status
	a_mid_block_run: assert property (@(posedge clk) disable iff (!arst_n)
		run_valid && !last |-> status == trbd_pkg::ST_OK && run_length != 16'd0)
		else $error("mid-block result without a run");

	a_run_bound: assert property (@(posedge clk) disable iff (!arst_n)
		run_valid |-> run_length <= trbd_pkg::MAX_TRACK_BYTES)
		else $error("run longer than a track");

endmodule
